/* rtl/core/ttmc_pkg.sv */
// Package: constants and register codes for the touch trimmed-mean calibration block.
`timescale 1ns / 1ps

package ttmc_pkg;

   // Burst geometry
   localparam int SAMPLES = 5;
   localparam int DROP    = 1;
   localparam int TRIM    = (2 * DROP < SAMPLES) ? DROP : (SAMPLES - 1) / 2;
   localparam int KEEP    = SAMPLES - 2 * TRIM;

   // Field widths
   localparam int SMP_W   = 12;
   localparam int GAIN_W  = 18;
   localparam int OFS_W   = 13;
   localparam int CTR_W   = 10;
   localparam int COORD_W = 15;
   localparam int CSR_W   = 18;
   localparam int CSR_IDX_W = 3;

   // Derived widths
   localparam int IDX_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int SUM_W  = SMP_W + $clog2(SAMPLES);

   // Divide by KEEP as a multiply by ceil(2^DIV_SH / KEEP), exact for any sum
   localparam int DIV_SH = SUM_W + $clog2(KEEP);
   localparam int DIV_M  = ((1 << DIV_SH) + KEEP - 1) / KEEP;
   localparam int RCP_W  = 2 * SUM_W + 1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_X_GAIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_Y_GAIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_X_OFFSET = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_Y_OFFSET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_RAW  = 3'd5;

   // Register reset values
   localparam logic signed [GAIN_W-1:0] RST_X_GAIN   = -18'sd28178;
   localparam logic signed [GAIN_W-1:0] RST_Y_GAIN   = -18'sd16488;
   localparam logic signed [OFS_W-1:0]  RST_X_OFFSET = 13'sd836;
   localparam logic signed [OFS_W-1:0]  RST_Y_OFFSET = 13'sd500;
   localparam logic [CTR_W-1:0]         RST_CENTER   = 10'd400;
   localparam logic [SMP_W-1:0]         RST_MIN_RAW  = 12'd100;

endpackage

/* rtl/core/touch_trimmed_mean_calibrate.sv */
// Top level: trimmed-mean touch filter with Q2.16 gain/offset calibration and x mirroring.
`timescale 1ns / 1ps

// Samples come in bursts of SAMPLES x values then SAMPLES y values; each sample is
// insertion-sorted into a small buffer by one shared compare-and-shift step per cycle.
// The last sample of a burst then runs the trimmed sum over the KEEP kept entries, the
// divide by KEEP (a multiply by its scaled reciprocal) and a step that stores the mean;
// the y burst then passes through the single shared multiplier and the output stage,
// which waits while the output register still holds a pending result. One result
// leaves per y burst, held in an output register; req_ready is high only while the
// sequencer is idle.
module touch_trimmed_mean_calibrate
   import ttmc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // input samples
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [SMP_W-1:0]          req_sample,
   input  logic                      req_axis,
   // results
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [COORD_W-1:0] rsp_x_coord,
   output logic signed [COORD_W-1:0] rsp_y_coord,
   output logic                      rsp_touch_valid,
   // configuration
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_W-1:0]          csr_wdata
);

   // Sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_INSERT = 3'd1;
   localparam logic [2:0] ST_SUM    = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_MEAN   = 3'd4;
   localparam logic [2:0] ST_MULX   = 3'd5;
   localparam logic [2:0] ST_MULY   = 3'd6;
   localparam logic [2:0] ST_FIN    = 3'd7;

   // Truncate toward zero after the Q16 product
   function automatic logic signed [15:0] scale_trunc(input logic signed [30:0] p);
      logic signed [31:0] t;
      t = {p[30], p} + (p[30] ? 32'sd65535 : 32'sd0);
      return t[31:16];
   endfunction

   // Clamp to the coordinate range
   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [17:0] v);
      logic [COORD_W-1:0] r;
      if (v[17:COORD_W-1] == {(18-COORD_W+1){v[17]}}) begin
         r = v[COORD_W-1:0];
      end else if (v[17]) begin
         r = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end
      return r;
   endfunction

   // Configuration registers
   logic signed [GAIN_W-1:0] x_gain_ff, x_gain_in;
   logic signed [GAIN_W-1:0] y_gain_ff, y_gain_in;
   logic signed [OFS_W-1:0]  x_offset_ff, x_offset_in;
   logic signed [OFS_W-1:0]  y_offset_ff, y_offset_in;
   logic [CTR_W-1:0]         center_ff, center_in;
   logic [SMP_W-1:0]         min_raw_ff, min_raw_in;

   // Sequencer and datapath
   logic [2:0]               state_ff, state_in;
   logic [IDX_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         j_ff, j_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic                     phase_y_ff, phase_y_in;
   logic [SMP_W-1:0]         smp_ff, smp_in;
   logic [SMP_W-1:0]         buf_ff [SAMPLES];
   logic [SMP_W-1:0]         buf_in [SAMPLES];
   logic [SUM_W-1:0]         quo_ff, quo_in;
   logic [SMP_W-1:0]         x_mean_ff, x_mean_in;
   logic [SMP_W-1:0]         y_mean_ff, y_mean_in;
   logic signed [30:0]       prod_ff, prod_in;
   logic signed [16:0]       sx_ff, sx_in;
   logic signed [COORD_W-1:0] last_x_ff, last_x_in;
   logic signed [COORD_W-1:0] last_y_ff, last_y_in;

   // Output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_x_in;
   logic signed [COORD_W-1:0] rsp_y_ff, rsp_y_in;
   logic                      rsp_tv_ff, rsp_tv_in;

   // Shared unit signals
   logic [IDX_W-1:0]          rd_addr;
   logic [SMP_W-1:0]          rd_data;
   logic signed [GAIN_W-1:0]  mul_a;
   logic signed [SMP_W:0]     mul_b;
   logic signed [30:0]        mul_p;
   logic [RCP_W-1:0]          recip_p;
   logic signed [16:0]        sy;
   logic signed [17:0]        x_full;
   logic                      reject;
   logic                      slot_free;
   logic                      req_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // One read port into the sort buffer
   assign rd_addr = (state_ff == ST_SUM) ? idx_ff : j_ff - 1'b1;
   assign rd_data = buf_ff[rd_addr];

   // Shared multiplier
   assign mul_a = (state_ff == ST_MULX) ? x_gain_ff : y_gain_ff;
   assign mul_b = (state_ff == ST_MULX) ? $signed({1'b0, x_mean_ff}) : $signed({1'b0, y_mean_ff});
   assign mul_p = mul_a * mul_b;

   // Trimmed sum times the scaled reciprocal of KEEP
   assign recip_p = {{(SUM_W+1){1'b0}}, quo_ff} * RCP_W'(DIV_M);

   // Calibration tail
   assign sy     = 17'(scale_trunc(prod_ff)) + 17'(y_offset_ff);
   assign x_full = $signed({7'b0, center_ff, 1'b0}) - $signed({sx_ff[16], sx_ff});
   assign reject = (x_mean_ff < min_raw_ff) || (y_mean_ff < min_raw_ff);

   // Configuration writes
   always_comb begin
      x_gain_in   = x_gain_ff;
      y_gain_in   = y_gain_ff;
      x_offset_in = x_offset_ff;
      y_offset_in = y_offset_ff;
      center_in   = center_ff;
      min_raw_in  = min_raw_ff;
      if (csr_we) begin
         case (csr_index)
            REG_X_GAIN:   x_gain_in   = csr_wdata[GAIN_W-1:0];
            REG_Y_GAIN:   y_gain_in   = csr_wdata[GAIN_W-1:0];
            REG_X_OFFSET: x_offset_in = csr_wdata[OFS_W-1:0];
            REG_Y_OFFSET: y_offset_in = csr_wdata[OFS_W-1:0];
            REG_CENTER:   center_in   = csr_wdata[CTR_W-1:0];
            REG_MIN_RAW:  min_raw_in  = csr_wdata[SMP_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      j_in       = j_ff;
      idx_in     = idx_ff;
      phase_y_in = phase_y_ff;
      smp_in     = smp_ff;
      buf_in     = buf_ff;
      quo_in     = quo_ff;
      x_mean_in  = x_mean_ff;
      y_mean_in  = y_mean_ff;
      prod_in    = prod_ff;
      sx_in      = sx_ff;
      last_x_in  = last_x_ff;
      last_y_in  = last_y_ff;
      rsp_x_in   = rsp_x_ff;
      rsp_y_in   = rsp_y_ff;
      rsp_tv_in  = rsp_tv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               smp_in = req_sample;
               if (req_axis != phase_y_ff) begin
                  // out of turn: drop partial burst, restart in x phase
                  phase_y_in = 1'b0;
                  count_in   = '0;
                  j_in       = '0;
                  if (!req_axis) begin
                     state_in = ST_INSERT;
                  end
               end else begin
                  j_in     = count_ff;
                  state_in = ST_INSERT;
               end
            end
         end
         ST_INSERT: begin
            // shift one larger entry up, or drop the sample into place
            if (j_ff != '0 && rd_data > smp_ff) begin
               buf_in[j_ff] = rd_data;
               j_in = j_ff - 1'b1;
            end else begin
               buf_in[j_ff] = smp_ff;
               if (count_ff == IDX_W'(SAMPLES - 1)) begin
                  count_in = '0;
                  quo_in   = '0;
                  idx_in   = IDX_W'(TRIM);
                  state_in = ST_SUM;
               end else begin
                  count_in = count_ff + 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SUM: begin
            quo_in = quo_ff + SUM_W'(rd_data);
            if (idx_ff == IDX_W'(SAMPLES - TRIM - 1)) begin
               state_in = ST_DIV;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DIV: begin
            // divide by KEEP: upper bits of the reciprocal product
            quo_in   = SUM_W'(recip_p[DIV_SH +: SMP_W]);
            state_in = ST_MEAN;
         end
         ST_MEAN: begin
            if (!phase_y_ff) begin
               x_mean_in  = quo_ff[SMP_W-1:0];
               phase_y_in = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               y_mean_in  = quo_ff[SMP_W-1:0];
               phase_y_in = 1'b0;
               state_in   = ST_MULX;
            end
         end
         ST_MULX: begin
            prod_in  = mul_p;
            state_in = ST_MULY;
         end
         ST_MULY: begin
            sx_in    = 17'(scale_trunc(prod_ff)) + 17'(x_offset_ff);
            prod_in  = mul_p;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // load the result once the output register is free
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (reject) begin
                  rsp_tv_in = 1'b0;
                  rsp_x_in  = last_x_ff;
                  rsp_y_in  = last_y_ff;
               end else begin
                  rsp_tv_in = 1'b1;
                  rsp_x_in  = sat_coord(x_full);
                  rsp_y_in  = sat_coord({sy[16], sy});
                  last_x_in = sat_coord(x_full);
                  last_y_in = sat_coord({sy[16], sy});
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_gain_ff    <= RST_X_GAIN;
         y_gain_ff    <= RST_Y_GAIN;
         x_offset_ff  <= RST_X_OFFSET;
         y_offset_ff  <= RST_Y_OFFSET;
         center_ff    <= RST_CENTER;
         min_raw_ff   <= RST_MIN_RAW;
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         phase_y_ff   <= 1'b0;
         x_mean_ff    <= '0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         x_gain_ff    <= x_gain_in;
         y_gain_ff    <= y_gain_in;
         x_offset_ff  <= x_offset_in;
         y_offset_ff  <= y_offset_in;
         center_ff    <= center_in;
         min_raw_ff   <= min_raw_in;
         state_ff     <= state_in;
         count_ff     <= count_in;
         phase_y_ff   <= phase_y_in;
         x_mean_ff    <= x_mean_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      j_ff      <= j_in;
      idx_ff    <= idx_in;
      smp_ff    <= smp_in;
      buf_ff    <= buf_in;
      quo_ff    <= quo_in;
      y_mean_ff <= y_mean_in;
      prod_ff   <= prod_in;
      sx_ff     <= sx_in;
      rsp_x_ff  <= rsp_x_in;
      rsp_y_ff  <= rsp_y_in;
      rsp_tv_ff <= rsp_tv_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_x_coord     = rsp_x_ff;
   assign rsp_y_coord     = rsp_y_ff;
   assign rsp_touch_valid = rsp_tv_ff;

`ifndef ASSERT_OFF
   // insertion never walks above the fill level
   a_insert_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT) |-> (j_ff <= count_ff))
      else $error("insert position above fill level");

   // a pending result blocks the output stage
   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_FIN))
      else $error("result overwritten while pending");

   // an out-of-turn y sample is dropped and resets the burst
   a_stray_y: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_axis && !phase_y_ff) |=>
         (state_ff == ST_IDLE && count_ff == '0 && !phase_y_ff))
      else $error("stray y sample not dropped");

   // a rejected read repeats the last coordinates
   a_reject_repeat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && slot_free && reject) |=>
         (rsp_valid_ff && !rsp_tv_ff && rsp_x_ff == $past(last_x_ff)
          && rsp_y_ff == $past(last_y_ff)))
      else $error("rejected read lost last coordinates");
`endif

endmodule
